// ===== sv/map_run_extent_coalescer_defines.svh =====
// assertion macros for the map run extent coalescer
`ifndef MAP_RUN_EXTENT_COALESCER_DEFINES_SVH
`define MAP_RUN_EXTENT_COALESCER_DEFINES_SVH
`ifndef SYNTHESIS
`define MREC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mrec assertion failed");
`define MREC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrec assertion failed");
`else
`define MREC_ASSERT(lbl, cond)
`define MREC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/mrec_pkg.sv =====
// types, constants and helpers for the map run extent coalescer
package mrec_pkg;

    localparam int INDEX_BITS_DEF = 32;
    localparam logic [31:0] UNMAPPED_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;
    localparam int QUEUE_DEPTH = 3;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS = 3;
    localparam logic [ADDR_BITS-1:0] ADDR_START_INDEX = 3'd0;

    typedef struct packed {
        logic        stream_done;
        logic        item_done;
        logic [31:0] extent_count;
        logic [31:0] ext_length;
        logic [31:0] ext_block;
        logic [31:0] ext_cluster;
    } res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        logic [31:0] y;
        y = (x == WORD_MAX) ? x : x + 32'd1;
        return y;
    endfunction

endpackage

// ===== sv/map_run_extent_coalescer.sv =====
// map run extent coalescer: turns a reverse-map stream into extents
//
// s_tdata carries one mapped cluster per block, blocks numbered from the
// start_index register; all-ones marks an unmapped block. s_tlast marks the
// last map entry of a stream and flushes the open run.
// m_tdata carries one extent (cluster, first block, length, running count);
// m_tuser flags the last extent caused by a request, m_tlast the extent
// flushed at end of stream.
// The APB port writes start_index at byte address 0; a write also reloads
// the block index. Write it only while the block is idle.
// Extents go out on m_* from a three-entry registered output queue.
// One request is taken per cycle while s_tready is high; a request may
// cause two extents, which drain one per cycle while m_tready is high.
// s_tready is high while at most one extent waits, so a stalled receiver
// stops input once the queue holds two or more extents.
// Reset closes the run, clears the count, empties the queue, and sets
// start_index and the block index to zero.
`include "map_run_extent_coalescer_defines.svh"

module map_run_extent_coalescer #(
    parameter int INDEX_BITS = mrec_pkg::INDEX_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // map_value
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ext_cluster, ext_block, ext_length, extent_count
    output logic [127:0]                   m_tdata,
    output logic                           m_tlast,
    output logic [0:0]                     m_tuser,  // item_done
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrec_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mrec_pkg::*;

    localparam int WIDE_BITS = INDEX_BITS + 32;

    logic [31:0]           start_index_reg;
    logic [31:0]           run_cluster_reg, run_cluster_next;
    logic [INDEX_BITS-1:0] run_block_reg, run_block_next;
    logic [31:0]           run_length_reg, run_length_next;
    logic                  run_open_reg, run_open_next;
    logic [INDEX_BITS-1:0] next_block_reg, next_block_next;
    logic [31:0]           total_reg, total_next;
    res_t                  q_reg [QUEUE_DEPTH];
    res_t                  q_next [QUEUE_DEPTH];
    res_t                  base_q [QUEUE_DEPTH];
    logic [CNT_BITS-1:0]   count_reg, count_next, cnt_pop;

    logic                  cfg_wr, in_acc, pop, unm, last, contig, emit_a, emit_b;
    logic                  last_acc;
    logic [31:0]           clu, count_a, count_b;
    logic [WIDE_BITS-1:0]  sum_w, blk_w, start_w, wr_w;
    logic [INDEX_BITS-1:0] blk, start_trunc;
    res_t                  res_a, res_b, res0, res1;
    logic [1:0]            n_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_START_INDEX);
    assign prdata = (paddr == ADDR_START_INDEX) ? start_index_reg : 32'd0;

    assign s_tready = (count_reg <= CNT_BITS'(1));
    assign in_acc   = s_tvalid && s_tready;
    assign last_acc = in_acc && s_tlast && !cfg_wr;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {q_reg[0].extent_count, q_reg[0].ext_length,
                       q_reg[0].ext_block, q_reg[0].ext_cluster};
    assign m_tlast  = q_reg[0].stream_done;
    assign m_tuser  = q_reg[0].item_done;

    // run compare
    assign clu         = s_tdata;
    assign last        = s_tlast;
    assign blk         = next_block_reg;
    assign unm         = (clu == UNMAPPED_VALUE);
    assign sum_w       = WIDE_BITS'(run_block_reg) + WIDE_BITS'(run_length_reg);
    assign blk_w       = WIDE_BITS'(run_block_reg);
    assign start_w     = WIDE_BITS'(start_index_reg);
    assign wr_w        = WIDE_BITS'(pwdata);
    assign start_trunc = start_w[INDEX_BITS-1:0];
    assign contig      = run_open_reg && (run_length_reg != WORD_MAX) &&
                         (blk == sum_w[INDEX_BITS-1:0]) &&
                         (clu == run_cluster_reg + run_length_reg);
    assign emit_a      = run_open_reg && (unm || !contig);
    assign emit_b      = !unm && last;
    assign count_a     = sat_inc(total_reg);
    assign count_b     = sat_inc(emit_a ? count_a : total_reg);
    assign n_res       = {1'b0, emit_a} + {1'b0, emit_b};

    always_comb
    begin
        run_cluster_next = run_cluster_reg;
        run_block_next   = run_block_reg;
        run_length_next  = run_length_reg;
        if (!unm)
        begin
            if (contig)
            begin
                run_length_next = run_length_reg + 32'd1;
            end
            else
            begin
                run_cluster_next = clu;
                run_block_next   = blk;
                run_length_next  = 32'd1;
            end
        end
        run_open_next   = !last && !unm;
        next_block_next = last ? start_trunc : blk + INDEX_BITS'(1);
        total_next      = last ? 32'd0 : (emit_a ? count_a : total_reg);

        res_a.ext_cluster  = run_cluster_reg;
        res_a.ext_block    = blk_w[31:0];
        res_a.ext_length   = run_length_reg;
        res_a.extent_count = count_a;
        res_a.stream_done  = unm && last;
        res_a.item_done    = 1'b0;

        res_b.ext_cluster  = run_cluster_next;
        res_b.ext_block    = 32'(WIDE_BITS'(run_block_next));
        res_b.ext_length   = run_length_next;
        res_b.extent_count = count_b;
        res_b.stream_done  = 1'b1;
        res_b.item_done    = 1'b1;

        res0           = emit_a ? res_a : res_b;
        res0.item_done = (n_res == 2'd1);
        res1           = res_b;
    end

    // output queue: shift on pop, append new extents behind
    always_comb
    begin
        cnt_pop = count_reg - CNT_BITS'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i + 1 < QUEUE_DEPTH))
            begin
                base_q[i] = q_reg[i + 1];
            end
            else
            begin
                base_q[i] = q_reg[i];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = base_q[i];
            if (in_acc && (n_res != 2'd0) && (CNT_BITS'(i) == cnt_pop))
            begin
                q_next[i] = res0;
            end
            if (in_acc && (n_res == 2'd2) && (CNT_BITS'(i) == cnt_pop + CNT_BITS'(1)))
            begin
                q_next[i] = res1;
            end
        end
        count_next = cnt_pop + (in_acc ? CNT_BITS'(n_res) : CNT_BITS'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_index_reg <= '0;
            run_cluster_reg <= '0;
            run_block_reg   <= '0;
            run_length_reg  <= '0;
            run_open_reg    <= 1'b0;
            next_block_reg  <= '0;
            total_reg       <= '0;
            count_reg       <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_wr)
            begin
                start_index_reg <= pwdata;
                next_block_reg  <= wr_w[INDEX_BITS-1:0];
            end
            else if (in_acc)
            begin
                run_cluster_reg <= run_cluster_next;
                run_block_reg   <= run_block_next;
                run_length_reg  <= run_length_next;
                run_open_reg    <= run_open_next;
                next_block_reg  <= next_block_next;
                total_reg       <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    `MREC_ASSERT(a_room_on_accept, !(s_tvalid && s_tready) || (count_reg <= CNT_BITS'(1)))
    `MREC_ASSERT_NEXT(a_last_closes, last_acc, !run_open_reg && (total_reg == 32'd0))
    `MREC_ASSERT(a_flush_is_item_end, !(m_tvalid && m_tlast) || m_tuser[0])

endmodule

// ===== tb/tb_map_run_extent_coalescer.sv =====
// self-checking testbench for the map run extent coalescer: directed and random map streams
`timescale 1ns / 100ps

class extent_scoreboard;
    logic [31:0] start_index;
    logic [31:0] run_cluster;
    logic [31:0] run_block;
    logic [31:0] run_length;
    bit          run_open;
    logic [31:0] next_block;
    logic [31:0] emitted_total;
    mrec_pkg::res_t expected_extents[$];
    int errors;
    int extents_seen;
    int streams_ended;

    function new();
        start_index = '0;
        run_cluster = '0;
        run_block = '0;
        run_length = '0;
        run_open = 0;
        next_block = '0;
        emitted_total = '0;
        errors = 0;
        extents_seen = 0;
        streams_ended = 0;
    endfunction

    function int pending();
        return expected_extents.size();
    endfunction

    function void set_start_index(logic [31:0] value);
        start_index = value;
        next_block = value;
    endfunction

    function void close_run(bit stream_end);
        mrec_pkg::res_t ext;
        if (emitted_total != mrec_pkg::WORD_MAX)
            emitted_total = emitted_total + 32'd1;
        ext.ext_cluster = run_cluster;
        ext.ext_block = run_block;
        ext.ext_length = run_length;
        ext.extent_count = emitted_total;
        ext.item_done = 1'b0;
        ext.stream_done = stream_end;
        expected_extents.push_back(ext);
        run_open = 0;
    endfunction

    function void note_request(logic [31:0] value, bit is_last);
        logic [31:0] blk;
        int before_cnt;
        bit contig;
        blk = next_block;
        before_cnt = expected_extents.size();
        if (value == mrec_pkg::UNMAPPED_VALUE)
        begin
            if (run_open)
                close_run(is_last);
        end
        else
        begin
            contig = run_open && run_length != mrec_pkg::WORD_MAX &&
                     blk == run_block + run_length &&
                     value == run_cluster + run_length;
            if (contig)
            begin
                run_length = run_length + 32'd1;
            end
            else
            begin
                if (run_open)
                    close_run(1'b0);
                run_cluster = value;
                run_block = blk;
                run_length = 32'd1;
                run_open = 1;
            end
            if (is_last)
                close_run(1'b1);
        end
        if (expected_extents.size() > before_cnt)
            expected_extents[expected_extents.size() - 1].item_done = 1'b1;
        if (is_last)
        begin
            run_open = 0;
            next_block = start_index;
            emitted_total = '0;
            streams_ended++;
        end
        else
        begin
            next_block = blk + 32'd1;
        end
    endfunction

    function void check_extent(logic [127:0] data, logic stream_flag, logic done_flag);
        mrec_pkg::res_t exp_ext;
        extents_seen++;
        if (expected_extents.size() == 0)
        begin
            $error("extent with nothing pending: cluster %0h block %0h length %0h",
                   data[31:0], data[63:32], data[95:64]);
            errors++;
            return;
        end
        exp_ext = expected_extents.pop_front();
        if (data[31:0] !== exp_ext.ext_cluster)
        begin
            $error("ext_cluster: expected %0h, got %0h", exp_ext.ext_cluster, data[31:0]);
            errors++;
        end
        if (data[63:32] !== exp_ext.ext_block)
        begin
            $error("ext_block: expected %0h, got %0h", exp_ext.ext_block, data[63:32]);
            errors++;
        end
        if (data[95:64] !== exp_ext.ext_length)
        begin
            $error("ext_length: expected %0h, got %0h", exp_ext.ext_length, data[95:64]);
            errors++;
        end
        if (data[127:96] !== exp_ext.extent_count)
        begin
            $error("extent_count: expected %0h, got %0h", exp_ext.extent_count, data[127:96]);
            errors++;
        end
        if (done_flag !== exp_ext.item_done)
        begin
            $error("item_done: expected %0b, got %0b", exp_ext.item_done, done_flag);
            errors++;
        end
        if (stream_flag !== exp_ext.stream_done)
        begin
            $error("stream_done: expected %0b, got %0b", exp_ext.stream_done, stream_flag);
            errors++;
        end
    endfunction
endclass

module tb_map_run_extent_coalescer;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;  // map_value
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [127:0]                   m_tdata;  // ext_cluster, ext_block, ext_length, extent_count
    logic                           m_tlast;
    logic [0:0]                     m_tuser;  // item_done
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mrec_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    extent_scoreboard sb;
    int  rx_hold;
    int  rx_stall;
    bit  rx_quiet;
    bit  tx_quiet;
    int  requests_sent;
    int  settings_used;
    logic [31:0] prev_cluster;

    map_run_extent_coalescer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("map_run_extent_coalescer regression: fail");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // result side: check on the edge, pick tready at the falling edge
    initial
    begin
        m_tready = 1'b0;
        rx_stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_extent(m_tdata, m_tlast, m_tuser[0]);
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_quiet)
            begin
                m_tready <= 1'b1;
            end
            else if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                rx_stall = idle_len();
                m_tready <= (rx_stall == 0);
                if (rx_stall > 0)
                    rx_stall--;
            end
        end
    end

    task automatic send_request(input logic [31:0] value, input bit is_last, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(value, is_last);
        requests_sent++;
    endtask

    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_start_index(input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= mrec_pkg::ADDR_START_INDEX;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_start_index(value);
        settings_used++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // read back
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            $error("start_index readback: expected %0h, got %0h", value, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_start_index();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] next_map_value();
        int r;
        logic [31:0] value;
        r = $urandom_range(0, 99);
        if (r < 65)
            value = prev_cluster + 32'd1;
        else if (r < 77)
            value = mrec_pkg::UNMAPPED_VALUE;
        else if (r < 95)
            value = $urandom;
        else
            value = $urandom_range(0, 15);
        if (value != mrec_pkg::UNMAPPED_VALUE)
            prev_cluster = value;
        return value;
    endfunction

    initial
    begin
        logic [31:0] value;
        bit is_last;
        sb = new();
        rx_hold = 0;
        rx_quiet = 0;
        tx_quiet = 0;
        requests_sent = 0;
        settings_used = 0;
        prev_cluster = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unmapped with no open run, then a bare end of stream
        send_request(mrec_pkg::UNMAPPED_VALUE, 1'b0, idle_len());
        send_request(mrec_pkg::UNMAPPED_VALUE, 1'b1, idle_len());
        send_request(32'd0, 1'b0, idle_len());
        send_request(32'd1, 1'b0, 0);
        send_request(32'd2, 1'b0, 0);
        send_request(32'd100, 1'b0, idle_len());
        send_request(mrec_pkg::UNMAPPED_VALUE, 1'b0, 0);
        send_request(32'hFFFF_FFFE, 1'b0, idle_len());
        send_request(32'd0, 1'b0, 0);
        send_request(32'd1, 1'b1, 0);
        settle_block();

        // block index wraps inside a run; last item both closes and flushes
        write_start_index(32'hFFFF_FFFE);
        send_request(32'd5, 1'b0, 0);
        send_request(32'd6, 1'b0, idle_len());
        send_request(32'd7, 1'b0, 0);
        send_request(32'd50, 1'b1, 0);
        send_request(32'h8000_0000, 1'b0, idle_len());
        send_request(mrec_pkg::UNMAPPED_VALUE, 1'b1, 0);
        settle_block();

        // register write with a run open breaks block contiguity
        write_start_index(32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFF, 1'b0, 0);
        send_request(32'h8000_0000, 1'b0, 0);
        settle_block();
        write_start_index(32'h0000_0010);
        send_request(32'h8000_0001, 1'b0, 0);
        send_request(32'h8000_0002, 1'b1, idle_len());
        send_request(32'h1234_5678, 1'b1, 0);
        settle_block();

        for (int phase = 0; phase < 13; phase++)
        begin
            write_start_index(pick_start_index());
            tx_quiet = (phase == 2) || ($urandom_range(0, 3) == 0);
            rx_quiet = (phase != 2) && ($urandom_range(0, 3) == 0);
            if (phase == 2)
                rx_hold = 60;
            for (int k = 0; k < 50; k++)
            begin
                value = next_map_value();
                is_last = ($urandom_range(0, 24) == 0);
                send_request(value, is_last, tx_quiet ? 0 : idle_len());
            end
            settle_block();
        end

        rx_quiet = 0;
        settle_block();
        $display("ran %0d map requests over %0d streams and %0d start_index settings",
                 requests_sent, sb.streams_ended, settings_used);
        $display("checked %0d extents, %0d mismatches", sb.extents_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("map_run_extent_coalescer regression: pass");
        end
        else
        begin
            $display("map_run_extent_coalescer regression: fail");
        end
        $finish;
    end

endmodule
